>>> rtl/assert_macros.svh
// Assertion helpers, clocked on clk, held off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/cpg_pkg.sv
package cpg_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int RADIUS_W       = 10;
  localparam int OFF_W          = 12;   // offsets, signed: y may reach -1
  localparam int DEC_W          = 16;   // decision, wraps
  localparam int QUEUE_DEPTH    = 2;
  localparam int POINTS         = 8;
  localparam int IDX_W          = $clog2(POINTS);

  localparam logic OP_START   = 1'b0;
  localparam logic OP_ADVANCE = 1'b1;

  // One octet job handed from front to back.
  typedef struct packed {
    logic signed [OFF_W-1:0] off_x;
    logic signed [OFF_W-1:0] off_y;
    logic                    dec_neg;
  } job_t;

  localparam int JOB_W = $bits(job_t);

endpackage

>>> rtl/cpg_front.sv
module cpg_front import cpg_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  logic                         full,
  input  logic                         op,
  input  logic signed [COORD_BITS-1:0] center_x,
  input  logic signed [COORD_BITS-1:0] center_y,
  input  logic        [RADIUS_W-1:0]   radius,
  output logic                         job_push,
  output job_t                         job,
  output logic signed [COORD_BITS-1:0] job_cx,
  output logic signed [COORD_BITS-1:0] job_cy
);

  logic                         active_r, active_nxt;
  logic signed [COORD_BITS-1:0] ctr_x_r, ctr_x_nxt;
  logic signed [COORD_BITS-1:0] ctr_y_r, ctr_y_nxt;
  logic signed [OFF_W-1:0]      off_x_r, off_x_nxt;
  logic signed [OFF_W-1:0]      off_y_r, off_y_nxt;
  logic        [DEC_W-1:0]      dec_r, dec_nxt;

  logic                         accept;
  logic                         dec_neg;
  logic signed [OFF_W-1:0]      x_adv, y_adv;
  logic signed [OFF_W:0]        diff;
  logic        [DEC_W-1:0]      step;
  logic        [DEC_W-1:0]      dec_start;

  assign accept  = push && !full;
  assign dec_neg = dec_r[DEC_W-1];
  assign x_adv   = off_x_r + OFF_W'(1);
  assign y_adv   = dec_neg ? off_y_r : off_y_r - OFF_W'(1);
  assign diff    = {off_x_r[OFF_W-1], off_x_r} - {off_y_r[OFF_W-1], off_y_r};
  // negative: 4x+6, else 4(x-y)+10
  assign step    = dec_neg
                 ? ({{(DEC_W-OFF_W){off_x_r[OFF_W-1]}}, off_x_r} << 2) + DEC_W'(6)
                 : ({{(DEC_W-OFF_W-1){diff[OFF_W]}}, diff} << 2) + DEC_W'(10);
  assign dec_start = DEC_W'(3) - DEC_W'({radius, 1'b0});

  always_comb begin
    active_nxt = active_r;
    ctr_x_nxt  = ctr_x_r;
    ctr_y_nxt  = ctr_y_r;
    off_x_nxt  = off_x_r;
    off_y_nxt  = off_y_r;
    dec_nxt    = dec_r;
    job_push   = 1'b0;
    if (accept) begin
      if (op == OP_START) begin
        active_nxt = 1'b1;
        ctr_x_nxt  = center_x;
        ctr_y_nxt  = center_y;
        off_x_nxt  = '0;
        off_y_nxt  = OFF_W'(radius);
        dec_nxt    = dec_start;
        job_push   = 1'b1;
      end else if (active_r) begin
        off_x_nxt = x_adv;
        off_y_nxt = y_adv;
        dec_nxt   = dec_r + step;
        if (x_adv <= y_adv) begin
          job_push = 1'b1;
        end else begin
          active_nxt = 1'b0;
        end
      end
    end
  end

  // Job carries the post-update state.
  assign job.off_x   = off_x_nxt;
  assign job.off_y   = off_y_nxt;
  assign job.dec_neg = dec_nxt[DEC_W-1];
  assign job_cx      = ctr_x_nxt;
  assign job_cy      = ctr_y_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else begin
      active_r <= active_nxt;
    end
    ctr_x_r <= ctr_x_nxt;
    ctr_y_r <= ctr_y_nxt;
    off_x_r <= off_x_nxt;
    off_y_r <= off_y_nxt;
    dec_r   <= dec_nxt;
  end

endmodule

>>> rtl/cpg_fifo.sv
module cpg_fifo import cpg_pkg::*; #(
  parameter int WIDTH = JOB_W,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_wr, do_rd;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      count_r <= count_r + CNT_W'(do_wr) - CNT_W'(do_rd);
    end
    if (do_wr) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

endmodule

>>> rtl/cpg_back.sv
module cpg_back import cpg_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_empty,
  input  job_t                         q_job,
  input  logic signed [COORD_BITS-1:0] q_cx,
  input  logic signed [COORD_BITS-1:0] q_cy,
  output logic                         q_pop,
  input  logic                         pop,
  output logic                         empty,
  output logic signed [COORD_BITS:0]   point_x,
  output logic signed [COORD_BITS:0]   point_y,
  output logic                         last_of_octet,
  output logic                         circle_done
);

  localparam int EXT_W = ((COORD_BITS > OFF_W) ? COORD_BITS : OFF_W) + 2;

  logic                         busy_r;
  logic [IDX_W-1:0]             idx_r;
  job_t                         job_r;
  logic signed [COORD_BITS-1:0] cx_r, cy_r;
  logic                         done_r;
  logic                         out_valid_r;
  logic signed [COORD_BITS:0]   px_r, py_r;
  logic                         last_r, odone_r;

  logic                         can_load, emit, at_last, take, done_nxt;
  logic signed [OFF_W-1:0]      a, b;
  logic signed [EXT_W-1:0]      a_ext, b_ext, cx_ext, cy_ext, px, py;
  logic signed [OFF_W:0]        qx, qy;

  assign can_load = !out_valid_r || pop;
  assign emit     = busy_r && can_load;
  assign at_last  = (idx_r == IDX_W'(POINTS - 1));
  assign take     = !q_empty && (!busy_r || (emit && at_last));
  assign q_pop    = take;

  // Next advance passes x>y: x+1 > (neg ? y : y-1)
  assign qx       = {q_job.off_x[OFF_W-1], q_job.off_x};
  assign qy       = {q_job.off_y[OFF_W-1], q_job.off_y};
  assign done_nxt = q_job.dec_neg ? (qx >= qy) : (qx + (OFF_W+1)'(1) >= qy);

  // Octet order: first four use (x,y), last four swap; bit0 negates x, bit1 y.
  assign a      = idx_r[2] ? job_r.off_y : job_r.off_x;
  assign b      = idx_r[2] ? job_r.off_x : job_r.off_y;
  assign a_ext  = EXT_W'(a);
  assign b_ext  = EXT_W'(b);
  assign cx_ext = EXT_W'(cx_r);
  assign cy_ext = EXT_W'(cy_r);
  assign px     = idx_r[0] ? cx_ext - a_ext : cx_ext + a_ext;
  assign py     = idx_r[1] ? cy_ext - b_ext : cy_ext + b_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (take) begin
        busy_r <= 1'b1;
        idx_r  <= '0;
      end else if (emit && at_last) begin
        busy_r <= 1'b0;
      end else if (emit) begin
        idx_r <= idx_r + IDX_W'(1);
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (pop) begin
        out_valid_r <= 1'b0;
      end
    end
    if (take) begin
      job_r  <= q_job;
      cx_r   <= q_cx;
      cy_r   <= q_cy;
      done_r <= done_nxt;
    end
    if (emit) begin
      px_r    <= px[COORD_BITS:0];
      py_r    <= py[COORD_BITS:0];
      last_r  <= at_last;
      odone_r <= done_r;
    end
  end

  assign empty         = !out_valid_r;
  assign point_x       = px_r;
  assign point_y       = py_r;
  assign last_of_octet = last_r;
  assign circle_done   = odone_r;

endmodule

>>> rtl/circle_point_generator.sv
// Channel   Ports                                              Handshake
// input     in_op, in_center_x, in_center_y, in_radius         push / full
// result    out_point_x, out_point_y, out_last_of_octet,       empty / pop
//           out_circle_done
//
// Output: each start or advance that plots gives eight words, one per cycle
//   while pop does not stall the output, from the single point generator
//   in the back end. An advance that ends the circle gives no words.
// Path from push: job queue, back-end job register, then output register.
// Reset: rst_n synchronous, active low; the block comes up idle and empty.
// Stalls: full rises while the job queue is full; pop stalls hold the output
//   word and, behind it, the back end, without losing words.
`include "assert_macros.svh"

module circle_point_generator import cpg_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  output logic                         full,
  input  logic                         in_op,
  input  logic signed [COORD_BITS-1:0] in_center_x,
  input  logic signed [COORD_BITS-1:0] in_center_y,
  input  logic        [RADIUS_W-1:0]   in_radius,
  output logic                         empty,
  input  logic                         pop,
  output logic signed [COORD_BITS:0]   out_point_x,
  output logic signed [COORD_BITS:0]   out_point_y,
  output logic                         out_last_of_octet,
  output logic                         out_circle_done
);

  localparam int QW = JOB_W + 2 * COORD_BITS;

  // front end -> job queue
  logic                         job_push;
  job_t                         job_in;
  logic signed [COORD_BITS-1:0] job_cx, job_cy;

  // job queue -> back end
  logic [QW-1:0]                q_rd;
  logic                         q_empty, q_pop;
  job_t                         q_job;
  logic signed [COORD_BITS-1:0] q_cx, q_cy;

  cpg_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .op       (in_op),
    .center_x (in_center_x),
    .center_y (in_center_y),
    .radius   (in_radius),
    .job_push (job_push),
    .job      (job_in),
    .job_cx   (job_cx),
    .job_cy   (job_cy)
  );

  cpg_fifo #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (job_push),
    .wr_data ({job_in, job_cx, job_cy}),
    .rd_en   (q_pop),
    .rd_data (q_rd),
    .full    (full),
    .empty   (q_empty)
  );

  assign {q_job, q_cx, q_cy} = q_rd;

  cpg_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_empty),
    .q_job         (q_job),
    .q_cx          (q_cx),
    .q_cy          (q_cy),
    .q_pop         (q_pop),
    .pop           (pop),
    .empty         (empty),
    .point_x       (out_point_x),
    .point_y       (out_point_y),
    .last_of_octet (out_last_of_octet),
    .circle_done   (out_circle_done)
  );

  // A job is only written when the queue has room (front gates on full).
  `ASSERT_IMPL(a_no_push_full, job_push, !full, "job written into full queue")

  // Inside an octet the back end never starves the output.
  `ASSERT_NEXT(a_octet_gapless, !empty && pop && !out_last_of_octet, !empty,
               "gap inside an octet")

  // circle_done is constant across the words of one octet.
  `ASSERT_NEXT(a_done_steady, !empty && pop && !out_last_of_octet,
               out_circle_done == $past(out_circle_done),
               "circle_done changed inside an octet")

endmodule

>>> dv/tb_circle_point_generator.sv
module tb_circle_point_generator;
  import cpg_pkg::*;

  localparam int CB         = COORD_BITS_DEF;
  localparam int RAND_ITEMS = 400;
  localparam int IDLE_LIMIT = 2000;  // cycles with no word moving on either side
  localparam int DRAIN_WAIT = 20;    // extra wait after the last expected word is checked

  // One plotted pixel as it leaves the block.
  typedef struct packed {
    logic signed [CB:0] x;
    logic signed [CB:0] y;
    logic               last;
    logic               done;
  } pixel_t;

  // Directed stimulus row. When 'typed' is set, the word count and the first
  // pixel are the hand-written expectation; the rest comes from the predictor.
  typedef struct {
    logic                 op;
    logic signed [CB-1:0] cx;
    logic signed [CB-1:0] cy;
    logic [RADIUS_W-1:0]  r;
    bit                   typed;
    int                   nw;
    logic signed [CB:0]   px0;
    logic signed [CB:0]   py0;
    logic                 dn0;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic push = 1'b0;
  logic full;
  logic in_op = OP_START;
  logic signed [CB-1:0] in_center_x = '0;
  logic signed [CB-1:0] in_center_y = '0;
  logic [RADIUS_W-1:0] in_radius = '0;
  logic empty;
  logic pop = 1'b0;
  logic signed [CB:0] out_point_x;
  logic signed [CB:0] out_point_y;
  logic out_last_of_octet;
  logic out_circle_done;

  // Side-band for typed rows, travels with the word being pushed.
  bit                 cur_typed = 1'b0;
  int                 cur_nw = 0;
  logic signed [CB:0] cur_px0 = '0;
  logic signed [CB:0] cur_py0 = '0;
  logic               cur_dn0 = 1'b0;

  int gap_pct = 0;    // sender idle chance, percent
  int stall_pct = 0;  // receiver stall chance, percent
  int errors = 0;
  int idle_cycles = 0;

  pixel_t pending_pixels[$];
  stim_row_t rows[$];

  // Rasterizer state mirror
  logic signed [CB-1:0] ctr_x = '0;
  logic signed [CB-1:0] ctr_y = '0;
  int                   off_x = 0;
  int                   off_y = 0;
  logic signed [DEC_W-1:0] dec = '0;
  bit                   circ_active = 1'b0;

  circle_point_generator #(.COORD_BITS(CB)) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_op            (in_op),
    .in_center_x      (in_center_x),
    .in_center_y      (in_center_y),
    .in_radius        (in_radius),
    .empty            (empty),
    .pop              (pop),
    .out_point_x      (out_point_x),
    .out_point_y      (out_point_y),
    .out_last_of_octet(out_last_of_octet),
    .out_circle_done  (out_circle_done)
  );

  always #5 clk = ~clk;

  // Midpoint step: updates the mirror and returns the octet it plots, if any.
  task automatic plot_step(input logic op, input logic signed [CB-1:0] cx,
                           input logic signed [CB-1:0] cy,
                           input logic [RADIUS_W-1:0] r,
                           output pixel_t octet[8], output int n);
    int d, a, b, cxi, cyi, nx, ny;
    logic dn;
    n = 0;
    if (op == OP_START) begin
      ctr_x = cx;
      ctr_y = cy;
      off_x = 0;
      off_y = int'(r);
      dec = DEC_W'(3 - 2 * off_y);
      circ_active = 1'b1;
    end else if (circ_active) begin
      d = dec;
      if (dec < 0) begin
        d = d + 4 * off_x + 6;
      end else begin
        d = d + 4 * (off_x - off_y) + 10;
        off_y = off_y - 1;
      end
      off_x = off_x + 1;
      dec = DEC_W'(d);
      if (off_x > off_y) circ_active = 1'b0;
    end
    if (!circ_active) return;
    // flag the octet if the next advance would cross the diagonal
    nx = off_x + 1;
    ny = (dec < 0) ? off_y : off_y - 1;
    dn = (nx > ny);
    cxi = ctr_x;
    cyi = ctr_y;
    for (int k = 0; k < 8; k++) begin
      a = (k < 4) ? off_x : off_y;
      b = (k < 4) ? off_y : off_x;
      octet[k].x = (CB+1)'(cxi + (k[0] ? -a : a));
      octet[k].y = (CB+1)'(cyi + (k[1] ? -b : b));
      octet[k].last = (k == 7);
      octet[k].done = dn;
    end
    n = 8;
  endtask

  // Input side: every accepted word runs through the predictor.
  always @(posedge clk) begin
    pixel_t octet[8];
    int n;
    if (rst_n && push && !full) begin
      plot_step(in_op, in_center_x, in_center_y, in_radius, octet, n);
      if (cur_typed) begin
        n = cur_nw;
        octet[0].x = cur_px0;
        octet[0].y = cur_py0;
        octet[0].last = 1'b0;
        octet[0].done = cur_dn0;
      end
      for (int k = 0; k < n; k++) pending_pixels.push_back(octet[k]);
    end
  end

  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  // Result side
  always @(posedge clk) begin
    pixel_t e;
    if (rst_n && pop && !empty) begin
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual x=%0d y=%0d", $time,
                 out_point_x, out_point_y);
        errors++;
      end else begin
        e = pending_pixels.pop_front();
        check_field("point_x", e.x, out_point_x);
        check_field("point_y", e.y, out_point_y);
        check_field("last_of_octet", e.last, out_last_of_octet);
        check_field("circle_done", e.done, out_circle_done);
      end
    end
  end

  // Receiver stalls, redrawn each cycle
  always @(negedge clk) pop <= ($urandom_range(99) >= stall_pct);

  // Watchdog: too long with no word moving on either side
  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Called at a falling edge, returns at the falling edge after acceptance.
  task automatic send_word(input logic op, input logic signed [CB-1:0] cx,
                           input logic signed [CB-1:0] cy,
                           input logic [RADIUS_W-1:0] r, input bit typed, input int nw,
                           input int px0, input int py0, input logic dn0);
    while ($urandom_range(99) < gap_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    in_op <= op;
    in_center_x <= cx;
    in_center_y <= cy;
    in_radius <= r;
    cur_typed <= typed;
    cur_nw <= nw;
    cur_px0 <= (CB+1)'(px0);
    cur_py0 <= (CB+1)'(py0);
    cur_dn0 <= dn0;
    @(posedge clk);
    while (full) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic add_row(input logic op, input int cx, input int cy, input int r,
                         input bit typed, input int nw, input int px0, input int py0,
                         input logic dn0);
    stim_row_t row;
    row.op = op;
    row.cx = CB'(cx);
    row.cy = CB'(cy);
    row.r = RADIUS_W'(r);
    row.typed = typed;
    row.nw = nw;
    row.px0 = (CB+1)'(px0);
    row.py0 = (CB+1)'(py0);
    row.dn0 = dn0;
    rows.push_back(row);
  endtask

  task automatic send_rand(input logic op, input logic [RADIUS_W-1:0] r);
    send_word(op, CB'($urandom), CB'($urandom), r, 1'b0, 0, 0, 0, 1'b0);
  endtask

  initial begin
    int counted;
    int sel;
    int nadv;
    logic [RADIUS_W-1:0] r;

    //      op          cx     cy     r     typed nw  px0    py0    done
    add_row(OP_ADVANCE, 0,     0,     0,    1,    0,  0,     0,     0);  // idle after reset
    add_row(OP_START,   0,     0,     0,    1,    8,  0,     0,     1);  // zero radius
    add_row(OP_ADVANCE, 0,     0,     0,    1,    0,  0,     0,     0);  // ends it
    add_row(OP_START,   2047,  2047,  1023, 1,    8,  2047,  3070,  0);
    add_row(OP_ADVANCE, 0,     0,     0,    0,    0,  0,     0,     0);
    add_row(OP_ADVANCE, -1,    -1,    1023, 0,    0,  0,     0,     0);
    add_row(OP_START,   -2048, -2048, 1023, 1,    8,  -2048, -1025, 0);
    add_row(OP_ADVANCE, 0,     0,     0,    0,    0,  0,     0,     0);
    add_row(OP_START,   -2048, 2047,  1023, 1,    8,  -2048, 3070,  0);  // restart mid-circle
    add_row(OP_START,   2047,  -2048, 0,    1,    8,  2047,  -2048, 1);
    add_row(OP_ADVANCE, 0,     0,     0,    1,    0,  0,     0,     0);
    add_row(OP_START,   5,     -7,    1,    1,    8,  5,     -6,    1);
    add_row(OP_ADVANCE, 0,     0,     0,    1,    0,  0,     0,     0);
    add_row(OP_ADVANCE, 0,     0,     0,    1,    0,  0,     0,     0);  // idle again
    add_row(OP_START,   1365,  -1366, 682,  0,    0,  0,     0,     0);
    add_row(OP_ADVANCE, 0,     0,     0,    0,    0,  0,     0,     0);
    add_row(OP_START,   -1366, 1365,  341,  0,    0,  0,     0,     0);
    add_row(OP_ADVANCE, 0,     0,     0,    0,    0,  0,     0,     0);
    add_row(OP_START,   100,   -100,  3,    0,    0,  0,     0,     0);
    for (int i = 0; i < 4; i++) add_row(OP_ADVANCE, 0, 0, 0, 0, 0, 0, 0, 0);

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed rows, no idling
    foreach (rows[i])
      send_word(rows[i].op, rows[i].cx, rows[i].cy, rows[i].r, rows[i].typed,
                rows[i].nw, rows[i].px0, rows[i].py0, rows[i].dn0);

    // random circles; idling profile steps through four phases
    counted = 0;
    while (counted < RAND_ITEMS) begin
      case (counted * 4 / RAND_ITEMS)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 51; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 51; end
        default: begin gap_pct = 29; stall_pct = 29; end
      endcase
      sel = $urandom_range(99);
      if (sel < 70) r = RADIUS_W'($urandom_range(15));
      else if (sel < 90) r = RADIUS_W'($urandom_range(100, 16));
      else r = RADIUS_W'($urandom_range(1023));
      send_rand(OP_START, r);
      counted++;
      if (r <= 100 && $urandom_range(99) < 75) begin
        // run the circle out, then poke it a little while idle
        while (circ_active) begin
          send_rand(OP_ADVANCE, RADIUS_W'($urandom));
          counted++;
        end
        nadv = $urandom_range(2);
        repeat (nadv) begin
          send_rand(OP_ADVANCE, RADIUS_W'($urandom));
          counted++;
        end
      end else begin
        // partial circle, abandoned by the next start
        nadv = $urandom_range(12);
        repeat (nadv) begin
          send_rand(OP_ADVANCE, RADIUS_W'($urandom));
          counted++;
        end
      end
    end
    push <= 1'b0;

    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (errors == 0 && pending_pixels.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
